>>> rtl/pfn_pkg.sv
// Shared constants, micro-step codes and the command struct for the fractal noise block.
// No dependencies; imported by pfn_ctrl, pfn_datapath, the top level and the bench.
`default_nettype none

package pfn_pkg;

   // fixed-point and table geometry
   localparam int FRAC        = 16;                 // fraction bits of offsets and fades
   localparam int PROD_FRAC   = 40;                 // fraction bits of coordinate * frequency
   localparam int PERM_AW     = 8;
   localparam int PERM_SIZE   = 1 << PERM_AW;
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = $clog2(MAX_OCTAVES);

   localparam logic [15:0] DIAG_GAIN = 16'd46341;   // round(0.7071 * 2^16)
   localparam logic [16:0] AMP_ONE   = 17'h10000;   // amplitude 1.0

   // input kinds (carried in tuser)
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // register map
   localparam logic [1:0] CSR_OCTAVE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_PERSISTENCE   = 2'd1;
   localparam logic [1:0] CSR_BASE_FREQ     = 2'd2;
   localparam logic [3:0]  OCT_RESET  = 4'd4;
   localparam logic [15:0] PERS_RESET = 16'd32768;
   localparam logic [23:0] BF_RESET   = 24'd335544;

   // micro-steps; the controller's state is the step in progress
   typedef logic [4:0] op_type;
   localparam op_type OP_IDLE  = 5'd0;
   localparam op_type OP_MX    = 5'd1;   // px = x * freq
   localparam op_type OP_MY    = 5'd2;   // py = y * freq, clear sums
   localparam op_type OP_CELL  = 5'd3;   // lattice cell and offsets
   localparam op_type OP_R0    = 5'd4;   // read perm[x0], t^2 (x)
   localparam op_type OP_R1    = 5'd5;   // read perm[x1], t^3 (x)
   localparam op_type OP_R2    = 5'd6;   // t^2 (y)
   localparam op_type OP_R3    = 5'd7;   // corner 00 read, t^3 (y)
   localparam op_type OP_R4    = 5'd8;   // corner 10 read, fade u
   localparam op_type OP_R5    = 5'd9;   // corner 01 read, fade v
   localparam op_type OP_R6    = 5'd10;  // corner 11 read, dot 00
   localparam op_type OP_R7    = 5'd11;  // dot 10
   localparam op_type OP_G01   = 5'd12;  // dot 01
   localparam op_type OP_G11   = 5'd13;  // dot 11
   localparam op_type OP_L0    = 5'd14;  // lerp along x, lower row
   localparam op_type OP_L1    = 5'd15;  // lerp along x, upper row
   localparam op_type OP_L2    = 5'd16;  // lerp along y
   localparam op_type OP_ACC   = 5'd17;  // weighted accumulate
   localparam op_type OP_AMP   = 5'd18;  // next amplitude
   localparam op_type OP_DPRE  = 5'd19;  // magnitude and divisor set-up
   localparam op_type OP_DSTEP = 5'd20;  // one quotient bit
   localparam op_type OP_FIN   = 5'd21;  // saturate and hand over

   localparam logic [4:0] DIV_LAST = 5'd16;  // 17 quotient bits

   typedef struct packed {
      op_type             op;
      logic [OCT_W-1:0]   octave;
      logic               capture;   // input beat accepted this cycle
      logic               emit;      // load the result register
   } dp_cmd_type;

endpackage

`default_nettype wire

>>> rtl/pfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/pfn_ctrl.sv
// Sequencer for the fractal noise block: steps through set-up, octaves and division.
// Depends on pfn_pkg; drives pfn_datapath through dp_cmd_type.
`default_nettype none

module pfn_ctrl import pfn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_func,
   input  wire logic [3:0] octave_count,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output dp_cmd_type      cmd
);

   op_type           state_ff, state_in;
   logic [OCT_W-1:0] oct_ff, oct_in, oct_last;
   logic [4:0]       div_cnt_ff, div_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, out_free, emit;

   assign req_tready = (state_ff == OP_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign emit       = (state_ff == OP_FIN) & out_free;

   // octave count 0 acts as 1, anything past the maximum as the maximum
   always_comb begin
      if (octave_count == 4'd0) begin
         oct_last = '0;
      end else if (octave_count > 4'(MAX_OCTAVES)) begin
         oct_last = OCT_W'(MAX_OCTAVES - 1);
      end else begin
         oct_last = OCT_W'(octave_count - 4'd1);
      end
   end

   always_comb begin
      state_in   = state_ff;
      oct_in     = oct_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         OP_IDLE: begin
            if (accept && req_func == FUNC_EVAL) begin
               state_in = OP_MX;
            end
         end
         OP_MY: begin
            oct_in   = '0;
            state_in = OP_CELL;
         end
         OP_MX, OP_CELL, OP_R0, OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_R6, OP_R7,
         OP_G01, OP_G11, OP_L0, OP_L1, OP_L2, OP_ACC: begin
            state_in = state_ff + 5'd1;
         end
         OP_AMP: begin
            if (oct_ff == oct_last) begin
               state_in = OP_DPRE;
            end else begin
               oct_in   = oct_ff + OCT_W'(1);
               state_in = OP_CELL;
            end
         end
         OP_DPRE: begin
            div_cnt_in = '0;
            state_in   = OP_DSTEP;
         end
         OP_DSTEP: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = OP_FIN;
            end else begin
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         OP_FIN: begin
            if (out_free) begin
               state_in = OP_IDLE;
            end
         end
         default: state_in = OP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= OP_IDLE;
         oct_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oct_ff       <= oct_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.op      = state_ff;
   assign cmd.octave  = oct_ff;
   assign cmd.capture = accept;
   assign cmd.emit    = emit;

endmodule

`default_nettype wire

>>> rtl/pfn_datapath.sv
// Datapath of the fractal noise block: one shared multiplier, fade, gradients,
// lerps, accumulation and a restoring divider. Depends on pfn_pkg.
`default_nettype none

module pfn_datapath import pfn_pkg::*; (
   input  wire logic               clock,
   input  wire dp_cmd_type         cmd,
   input  wire logic [31:0]        x_coord,
   input  wire logic [31:0]        y_coord,
   input  wire logic [15:0]        persistence,
   input  wire logic [23:0]        base_frequency,
   output logic      [PERM_AW-1:0] ram_rd_addr,
   input  wire logic [7:0]         ram_rd_data,
   output logic signed [15:0]      noise_value
);

   localparam int SH_BASE = PROD_FRAC - FRAC;

   logic [31:0]          x_ff, y_ff;
   logic [55:0]          px_ff, py_ff;
   logic [FRAC-1:0]      tx_ff, ty_ff;
   logic [PERM_AW-1:0]   x0_ff, y0_ff, h0_ff, h1_ff;
   logic [2:0]           hc_ff [4];
   logic [FRAC-1:0]      t2x_ff, t3x_ff, t2y_ff, t3y_ff;
   logic [16:0]          fu_ff, fv_ff;
   logic signed [18:0]   g_ff [4];
   logic signed [19:0]   l0_ff, l1_ff, nz_ff;
   logic [16:0]          amp_ff;
   logic [19:0]          asum_ff;
   logic signed [39:0]   total_ff;
   logic [39:0]          mag_ff;
   logic [36:0]          dsh_ff;
   logic                 neg_ff;
   logic [16:0]          quo_ff;
   logic [15:0]          rsp_data_ff;

   logic [4:0]           shamt;
   logic [55:0]          px_sh, py_sh;
   logic [22:0]          qx_w, qy_w;
   logic [1:0]           corner;
   logic [2:0]           hsel;
   logic signed [16:0]   dx, dy;
   logic signed [18:0]   s_dot, g_in;
   logic signed [19:0]   diff, lerp_base, lerp_in;
   logic signed [33:0]   mul_a;
   logic signed [24:0]   mul_b;
   logic signed [58:0]   mul_p;
   logic                 ge;
   logic [15:0]          res_in;

   // lattice cell and offset for this octave
   assign shamt = 5'(SH_BASE) - 5'(cmd.octave);
   assign px_sh = px_ff >> shamt;
   assign py_sh = py_ff >> shamt;

   // quintic fade, second factor: 6t^2 - 15t + 10
   assign qx_w = 23'(t2x_ff) * 23'd6 + 23'(10 << FRAC) - 23'(tx_ff) * 23'd15;
   assign qy_w = 23'(t2y_ff) * 23'd6 + 23'(10 << FRAC) - 23'(ty_ff) * 23'd15;

   // gradient selection for the corner in hand
   always_comb begin
      case (cmd.op)
         OP_R6:   corner = 2'd0;
         OP_R7:   corner = 2'd1;
         OP_G01:  corner = 2'd2;
         default: corner = 2'd3;
      endcase
   end

   assign hsel = hc_ff[corner];
   assign dx   = corner[0] ? $signed({1'b1, tx_ff}) : $signed({1'b0, tx_ff});
   assign dy   = corner[1] ? $signed({1'b1, ty_ff}) : $signed({1'b0, ty_ff});

   always_comb begin
      case (hsel)
         3'd0:    s_dot = 19'(dx);
         3'd1:    s_dot = -19'(dx);
         3'd2:    s_dot = 19'(dy);
         3'd3:    s_dot = -19'(dy);
         3'd4:    s_dot = 19'(dx) + 19'(dy);
         3'd5:    s_dot = 19'(dy) - 19'(dx);
         3'd6:    s_dot = 19'(dx) - 19'(dy);
         default: s_dot = -19'(dx) - 19'(dy);
      endcase
   end

   // lerp operands
   always_comb begin
      case (cmd.op)
         OP_L0: begin
            lerp_base = 20'(g_ff[0]);
            diff      = 20'(g_ff[1]) - 20'(g_ff[0]);
         end
         OP_L1: begin
            lerp_base = 20'(g_ff[2]);
            diff      = 20'(g_ff[3]) - 20'(g_ff[2]);
         end
         default: begin
            lerp_base = l0_ff;
            diff      = l1_ff - l0_ff;
         end
      endcase
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MX: begin
            mul_a = $signed(34'(x_ff));
            mul_b = $signed(25'(base_frequency));
         end
         OP_MY: begin
            mul_a = $signed(34'(y_ff));
            mul_b = $signed(25'(base_frequency));
         end
         OP_R0: begin
            mul_a = $signed(34'(tx_ff));
            mul_b = $signed(25'(tx_ff));
         end
         OP_R1: begin
            mul_a = $signed(34'(t2x_ff));
            mul_b = $signed(25'(tx_ff));
         end
         OP_R2: begin
            mul_a = $signed(34'(ty_ff));
            mul_b = $signed(25'(ty_ff));
         end
         OP_R3: begin
            mul_a = $signed(34'(t2y_ff));
            mul_b = $signed(25'(ty_ff));
         end
         OP_R4: begin
            mul_a = $signed(34'(t3x_ff));
            mul_b = $signed(25'(qx_w[20:0]));
         end
         OP_R5: begin
            mul_a = $signed(34'(t3y_ff));
            mul_b = $signed(25'(qy_w[20:0]));
         end
         OP_R6, OP_R7, OP_G01, OP_G11: begin
            mul_a = 34'(s_dot);
            mul_b = $signed(25'(DIAG_GAIN));
         end
         OP_L0, OP_L1: begin
            mul_a = 34'(diff);
            mul_b = $signed(25'(fu_ff));
         end
         OP_L2: begin
            mul_a = 34'(diff);
            mul_b = $signed(25'(fv_ff));
         end
         OP_ACC: begin
            mul_a = 34'(nz_ff);
            mul_b = $signed(25'(amp_ff));
         end
         OP_AMP: begin
            mul_a = $signed(34'(amp_ff));
            mul_b = $signed(25'(persistence));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // diagonal gradients take the scaled product, axis ones the unscaled value
   assign g_in    = hsel[2] ? mul_p[FRAC+18:FRAC] : s_dot;
   assign lerp_in = lerp_base + mul_p[FRAC+19:FRAC];

   // table reads: row hashes first, then the four corners
   always_comb begin
      case (cmd.op)
         OP_R1:   ram_rd_addr = x0_ff + PERM_AW'(1);
         OP_R3:   ram_rd_addr = h0_ff + y0_ff;
         OP_R4:   ram_rd_addr = h1_ff + y0_ff;
         OP_R5:   ram_rd_addr = h0_ff + y0_ff + PERM_AW'(1);
         OP_R6:   ram_rd_addr = h1_ff + y0_ff + PERM_AW'(1);
         default: ram_rd_addr = x0_ff;
      endcase
   end

   assign ge = (mag_ff >= 40'(dsh_ff));

   always_comb begin
      if (neg_ff) begin
         res_in = (quo_ff > 17'd32768) ? 16'h8000 : 16'(-quo_ff);
      end else begin
         res_in = (quo_ff > 17'd32767) ? 16'h7fff : quo_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= x_coord;
         y_ff <= y_coord;
      end
      case (cmd.op)
         OP_MX: px_ff <= mul_p[55:0];
         OP_MY: begin
            py_ff    <= mul_p[55:0];
            amp_ff   <= AMP_ONE;
            asum_ff  <= '0;
            total_ff <= '0;
         end
         OP_CELL: begin
            tx_ff <= px_sh[FRAC-1:0];
            ty_ff <= py_sh[FRAC-1:0];
            x0_ff <= px_sh[FRAC+PERM_AW-1:FRAC];
            y0_ff <= py_sh[FRAC+PERM_AW-1:FRAC];
         end
         OP_R0: t2x_ff <= mul_p[2*FRAC-1:FRAC];
         OP_R1: begin
            t3x_ff <= mul_p[2*FRAC-1:FRAC];
            h0_ff  <= ram_rd_data;
         end
         OP_R2: begin
            t2y_ff <= mul_p[2*FRAC-1:FRAC];
            h1_ff  <= ram_rd_data;
         end
         OP_R3: t3y_ff <= mul_p[2*FRAC-1:FRAC];
         OP_R4: begin
            fu_ff    <= mul_p[FRAC+16:FRAC];
            hc_ff[0] <= ram_rd_data[2:0];
         end
         OP_R5: begin
            fv_ff    <= mul_p[FRAC+16:FRAC];
            hc_ff[1] <= ram_rd_data[2:0];
         end
         OP_R6: begin
            g_ff[0]  <= g_in;
            hc_ff[2] <= ram_rd_data[2:0];
         end
         OP_R7: begin
            g_ff[1]  <= g_in;
            hc_ff[3] <= ram_rd_data[2:0];
         end
         OP_G01: g_ff[2] <= g_in;
         OP_G11: g_ff[3] <= g_in;
         OP_L0:  l0_ff <= lerp_in;
         OP_L1:  l1_ff <= lerp_in;
         OP_L2:  nz_ff <= lerp_in;
         OP_ACC: begin
            total_ff <= total_ff + mul_p[39:0];
            asum_ff  <= asum_ff + 20'(amp_ff);
         end
         OP_AMP: amp_ff <= mul_p[32:16];
         OP_DPRE: begin
            neg_ff <= total_ff[39];
            mag_ff <= total_ff[39] ? 40'(-total_ff) : 40'(total_ff);
            dsh_ff <= {asum_ff, 1'b0, 16'b0};
            quo_ff <= '0;
         end
         OP_DSTEP: begin
            if (ge) begin
               mag_ff <= mag_ff - 40'(dsh_ff);
            end
            quo_ff <= {quo_ff[15:0], ge};
            dsh_ff <= dsh_ff >> 1;
         end
         default: ;
      endcase
      if (cmd.emit) begin
         rsp_data_ff <= res_in;
      end
   end

   assign noise_value = $signed(rsp_data_ff);

endmodule

`default_nettype wire

>>> rtl/perlin_fbm_noise_2d.sv
// Top level of the 2-D Perlin gradient noise block with octave summing.
// Depends on pfn_pkg, pfn_ram, pfn_ctrl and pfn_datapath.
//
// Use: req_ beats carry either a table load (tuser = 0) or a point to evaluate
// (tuser = 1). A load writes one byte of the 256-entry permutation table in the
// beat's cycle and gives no rsp_ beat; the next beat is taken straight away.
// An evaluate beat gives one rsp_ beat holding the signed Q1.15 noise value.
// Every table entry that a point touches must have been loaded first.
// An evaluate runs the set-up steps (OP_MX, OP_MY), the octave loop (OP_CELL to
// OP_AMP) once per octave, the division (OP_DPRE and one OP_DSTEP per quotient
// bit) and the hand-over step (OP_FIN). All multiplies share one 34 x 25
// multiplier and the table has one read port, so these steps run one after
// another; one point is in work at a time and req_tready is low while it is.
// The result sits in an output register: while rsp_tready is held low the
// block still finishes, parks in the hand-over step and waits; a load may be
// accepted as soon as the evaluate has reached that register.
// csr_ writes (index 0 octave count, 1 persistence, 2 base frequency) are
// always ready and belong only in idle periods. Reset is synchronous and
// restores the register defaults; the table contents are not cleared.
`default_nettype none

module perlin_fbm_noise_2d import pfn_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // perm_index[7:0], perm_value[15:8],
                                         // x_coord[47:16], y_coord[79:48]
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // noise_value[15:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   logic [3:0]         octave_count_ff;
   logic [15:0]        persistence_ff;
   logic [23:0]        base_frequency_ff;
   logic               ram_we;
   logic [PERM_AW-1:0] ram_rd_addr;
   logic [7:0]         ram_rd_data;
   logic signed [15:0] noise_value;
   dp_cmd_type         cmd;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff   <= OCT_RESET;
         persistence_ff    <= PERS_RESET;
         base_frequency_ff <= BF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff   <= csr_wdata[3:0];
            CSR_PERSISTENCE:  persistence_ff    <= csr_wdata[15:0];
            CSR_BASE_FREQ:    base_frequency_ff <= csr_wdata;
            default: ;  // unmapped index
         endcase
      end
   end

   // table loads go straight into the RAM on the accepted beat
   assign ram_we = req_tvalid & req_tready & (req_tuser == FUNC_LOAD);

   pfn_ram #(
      .WIDTH (8),
      .DEPTH (PERM_SIZE)
   ) u_perm (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_tdata[PERM_AW-1:0]),
      .wr_data (req_tdata[15:8]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfn_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser),
      .octave_count (octave_count_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd)
   );

   pfn_datapath u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .x_coord        (req_tdata[47:16]),
      .y_coord        (req_tdata[79:48]),
      .persistence    (persistence_ff),
      .base_frequency (base_frequency_ff),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .noise_value    (noise_value)
   );

   assign rsp_tdata = noise_value;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for perlin_fbm_noise_2d: table loads and point evaluates on
// the req_/rsp_ streams, checked beat by beat against an in-bench noise predictor.
// Depends on pfn_pkg and the RTL under rtl/.
`default_nettype none

module tb_top import pfn_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // perm_index, perm_value, x_coord, y_coord from bit 0 up
   logic        req_tuser = FUNC_LOAD;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // noise_value
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_OCTAVE_COUNT;
   logic [23:0] csr_wdata = '0;

   perlin_fbm_noise_2d dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: table copy and register copies
   logic [7:0]  perm_copy [PERM_SIZE];
   logic [3:0]  octaves_cfg = OCT_RESET;
   logic [15:0] persist_cfg = PERS_RESET;
   logic [23:0] freq_cfg    = BF_RESET;

   logic signed [15:0] noise_due [$];   // expected noise values, oldest first
   int  errors    = 0;
   bit  no_idle   = 1'b0;   // burst stretches: neither side idles
   bit  long_hold = 1'b0;   // one-off long receiver hold-off
   int  quiet     = 0;      // cycles without any beat

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // noise predictor
   // ---------------------------------------------------------------------
   function automatic longint fade_q(longint t);
      longint t2, t3, q;
      t2 = (t * t) >>> FRAC;
      t3 = (t2 * t) >>> FRAC;
      q  = 6 * t2 + 10 * 65536 - 15 * t;
      return (t3 * q) >>> FRAC;
   endfunction

   // eight gradient directions; diagonals scaled by ~1/sqrt(2), floor shift
   function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
      longint g;
      g = longint'(DIAG_GAIN);
      case (h[2:0])
         3'd0: return dx;
         3'd1: return -dx;
         3'd2: return dy;
         3'd3: return -dy;
         3'd4: return (g * (dx + dy)) >>> FRAC;
         3'd5: return (g * (dy - dx)) >>> FRAC;
         3'd6: return (g * (dx - dy)) >>> FRAC;
         default: return (g * (-dx - dy)) >>> FRAC;
      endcase
   endfunction

   function automatic longint mix(longint a, longint b, longint w);
      return a + ((w * (b - a)) >>> FRAC);
   endfunction

   function automatic logic [7:0] corner_hash(int cx, int cy);
      logic [7:0] first;
      first = perm_copy[cx & 255];
      return perm_copy[(int'(first) + cy) & 255];
   endfunction

   function automatic longint layer_noise(longint px, longint py, int oct);
      int     x0, y0, x1, y1;
      longint tx, ty, u, v, d00, d10, d01, d11;
      x0 = int'((px >> (PROD_FRAC - oct)) & 255);
      y0 = int'((py >> (PROD_FRAC - oct)) & 255);
      x1 = (x0 + 1) & 255;
      y1 = (y0 + 1) & 255;
      tx = (px >> (PROD_FRAC - FRAC - oct)) & 65535;
      ty = (py >> (PROD_FRAC - FRAC - oct)) & 65535;
      u  = fade_q(tx);
      v  = fade_q(ty);
      d00 = grad_dot(corner_hash(x0, y0), tx, ty);
      d10 = grad_dot(corner_hash(x1, y0), tx - 65536, ty);
      d01 = grad_dot(corner_hash(x0, y1), tx, ty - 65536);
      d11 = grad_dot(corner_hash(x1, y1), tx - 65536, ty - 65536);
      return mix(mix(d00, d10, u), mix(d01, d11, u), v);
   endfunction

   function automatic logic signed [15:0] fbm_value(logic [31:0] x, logic [31:0] y);
      longint px, py, amp, amp_sum, total, mag;
      int     n;
      px = longint'(x) * longint'(freq_cfg);
      py = longint'(y) * longint'(freq_cfg);
      n  = (octaves_cfg == 0) ? 1 : (octaves_cfg > MAX_OCTAVES) ? MAX_OCTAVES : octaves_cfg;
      amp = 65536; amp_sum = 0; total = 0;
      for (int i = 0; i < n; i++) begin
         total   += layer_noise(px, py, i) * amp;
         amp_sum += amp;
         amp      = (amp * longint'(persist_cfg)) >> 16;
      end
      if (total >= 0) begin
         mag = (total <<< 15) / (amp_sum <<< FRAC);
         return (mag > 32767) ? 16'sd32767 : 16'(mag);
      end else begin
         mag = ((-total) <<< 15) / (amp_sum <<< FRAC);
         return (mag > 32768) ? -16'sd32768 : 16'(-mag);
      end
   endfunction

   // ---------------------------------------------------------------------
   // sender: one req_ beat; a typed expectation overrides the predictor
   // ---------------------------------------------------------------------
   task automatic send_beat(logic fn, logic [7:0] idx, logic [7:0] val,
                            logic [31:0] x, logic [31:0] y,
                            bit typed = 0, logic signed [15:0] typed_val = '0);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {y, x, val, idx};
      do @(posedge clock); while (!req_tready);
      if (fn == FUNC_LOAD)
         perm_copy[idx] = val;
      else
         noise_due = {noise_due, (typed ? typed_val : fbm_value(x, y))};
   endtask

   // park the sender until every result is back, then cover the block's tail
   task automatic drain(int tail);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (noise_due.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic csr_write(logic [1:0] idx, logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OCTAVE_COUNT: octaves_cfg = data[3:0];
         CSR_PERSISTENCE:  persist_cfg = data[15:0];
         CSR_BASE_FREQ:    freq_cfg    = data;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // receiver: random back-pressure, one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 7);
         if (long_hold) begin
            gap = 300;
            long_hold = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_due.size() == 0)
            report_mismatch("unexpected rsp beat, noise_value", $signed(rsp_tdata), 0);
         else begin
            logic signed [15:0] want;
            want = noise_due.pop_front();
            if ($signed(rsp_tdata) !== want)
               report_mismatch("noise_value", $signed(rsp_tdata), want);
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 4000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // directed rows, checked under the reset register values
   // ---------------------------------------------------------------------
   typedef struct {
      logic               fn;
      logic [7:0]         idx;
      logic [7:0]         val;
      logic [31:0]        x;
      logic [31:0]        y;
      bit                 typed;
      logic signed [15:0] want;
   } stim_row_type;

   localparam int N_ROWS = 16;
   stim_row_type rows [N_ROWS] = '{
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 1, 16'sd0},  // origin is zero
      '{FUNC_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0, 16'sd0},
      '{FUNC_LOAD, 8'h00, 8'hFF, 32'h0000_0000, 32'h0000_0000, 0, 16'sd0},
      '{FUNC_LOAD, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'sd0},
      '{FUNC_EVAL, 8'hFF, 8'hFF, 32'h0001_0000, 32'h0000_8000, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'sd0},
      '{FUNC_LOAD, 8'hAA, 8'h55, 32'h0000_0000, 32'h0000_0000, 0, 16'sd0},
      '{FUNC_LOAD, 8'h55, 8'hAA, 32'h0000_0000, 32'h0000_0000, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h0032_0000, 32'h0032_0000, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h00C8_4000, 32'h0064_C000, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h0000_0001, 32'h0000_0001, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h5555_5555, 32'hAAAA_AAAA, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'hAAAA_AAAA, 32'h5555_5555, 0, 16'sd0},
      '{FUNC_EVAL, 8'h00, 8'h00, 32'h1234_5678, 32'h9ABC_DEF0, 0, 16'sd0}
   };

   // per-phase register settings; the first phase keeps the reset values
   localparam int N_PHASES = 8;
   localparam int PHASE_BEATS = 140;

   initial begin
      logic [31:0] x, y;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // whole table first, so no evaluate ever touches an unwritten entry
      for (int i = 0; i < PERM_SIZE; i++)
         send_beat(FUNC_LOAD, 8'(i), 8'($urandom_range(0, 255)), $urandom, $urandom);

      foreach (rows[r])
         send_beat(rows[r].fn, rows[r].idx, rows[r].val, rows[r].x, rows[r].y,
                   rows[r].typed, rows[r].want);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            drain(160);
            case (ph)
               1: begin   // heaviest: all octaves, almost no falloff, top frequency
                  csr_write(CSR_OCTAVE_COUNT, 24'd8);
                  csr_write(CSR_PERSISTENCE, 24'hFFFF);
                  csr_write(CSR_BASE_FREQ, 24'hFF_FFFF);
               end
               2: begin   // lightest: one octave, zero frequency
                  csr_write(CSR_OCTAVE_COUNT, 24'd1);
                  csr_write(CSR_PERSISTENCE, 24'd0);
                  csr_write(CSR_BASE_FREQ, 24'd0);
               end
               3: begin   // octave count zero is taken as one
                  csr_write(CSR_OCTAVE_COUNT, 24'd0);
                  csr_write(CSR_PERSISTENCE, 24'd1);
                  csr_write(CSR_BASE_FREQ, 24'd1);
               end
               4: begin   // above the maximum is clamped
                  csr_write(CSR_OCTAVE_COUNT, 24'd15);
                  csr_write(CSR_PERSISTENCE, 24'($urandom_range(0, 65535)));
                  csr_write(CSR_BASE_FREQ, 24'($urandom_range(0, 24'hFF_FFFF)));
               end
               default: begin
                  csr_write(CSR_OCTAVE_COUNT, 24'($urandom_range(0, 15)));
                  csr_write(CSR_PERSISTENCE, 24'($urandom_range(0, 65535)));
                  csr_write(CSR_BASE_FREQ, ($urandom_range(0, 1) == 1)
                            ? 24'($urandom_range(0, 24'hFF_FFFF))
                            : 24'($urandom_range(0, 24'h0F_FFFF)));
               end
            endcase
            csr_valid <= 1'b0;
         end
         no_idle = (ph == 3);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (ph == 1 && k == 20)
               long_hold = 1'b1;   // receiver stalls, block fills and stalls req_
            if (ph == 2 && k == 90)
               drain(0);           // sender waits for every result
            // mostly small coordinates so cells stay near the origin
            x = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            y = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            if ($urandom_range(0, 4) == 0)
               send_beat(FUNC_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         x, y);
            else
               send_beat(FUNC_EVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         x, y);
         end
      end

      drain(200);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
